// ===== rtl/core/pls_pkg.sv =====
package pls_pkg;

    // vector components and unit vectors
    localparam int CMP_W     = 16;
    localparam int VEC_N     = 3;
    localparam int MAG_W     = 30;
    localparam int SCALE_MSB = MAG_W - 1;
    localparam int SH_W      = 5;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = 64;
    localparam int Q_FRAC    = 30;
    localparam int LEN_W     = 31;
    localparam int Q_W       = 31;
    localparam int REM_W     = 62;
    localparam int UNIT_W    = 32;
    localparam int PROD_W    = 64;

    // pipeline depths
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = LEN_W;
    localparam int NORM_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int SHINE_W    = 8;
    localparam int PW_STEPS   = SHINE_W;
    localparam int ST_F1      = NORM_LAT + 8 + PW_STEPS;
    localparam int ST_F3      = ST_F1 + 2;
    localparam int TOTAL_LAT  = ST_F1 + 4;

    // colors, gains, outputs
    localparam int GAIN_W  = 16;
    localparam int RGB_W   = 3 * GAIN_W;
    localparam int STR_W   = 32;
    localparam int OUT_W   = 32;
    localparam int AMB_SH  = 12;
    localparam int DIF_SH1 = 18;
    localparam int DIF_SH2 = 24;
    localparam int AMB_W   = GAIN_W + STR_W - AMB_SH;
    localparam int KDD_W   = GAIN_W + Q_W;
    localparam int DIF_W   = KDD_W - DIF_SH1 + STR_W - DIF_SH2;
    localparam int LCKS_W  = 2 * GAIN_W;
    localparam int SP_W    = 32;
    localparam int SPC_W   = SP_W + STR_W - DIF_SH2;
    localparam int TOT_W   = SPC_W + 1;

    // stream and config widths
    localparam int IN_TW  = VEC_N * VEC_N * CMP_W + RGB_W + STR_W;
    localparam int OUT_TW = 3 * OUT_W;
    localparam int CFG_W  = RGB_W;
    localparam int CFG_AW = 2;

    localparam logic [PROD_W-1:0] ONE_Q30 = PROD_W'(1) << Q_FRAC;
    localparam logic signed [PROD_W-1:0] ONE_Q30_S = PROD_W'(1) << Q_FRAC;

    typedef logic signed [CMP_W-1:0]  comp_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_AMBIENT   = 2'd0,
        REG_DIFFUSE   = 2'd1,
        REG_SPECULAR  = 2'd2,
        REG_SHININESS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [RGB_W-1:0] color;
        logic [STR_W-1:0] strength;
    } side_t;

    // magnitude scaled down from q2.60 and capped at one
    function automatic logic [Q_W-1:0] clamp_mag(input logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] t;
        t = m >> Q_FRAC;
        return (t > ONE_Q30) ? Q_W'(ONE_Q30) : Q_W'(t);
    endfunction

    // positive part of a q2.60 dot product as q1.30
    function automatic logic [Q_W-1:0] clamp_pos(input logic [PROD_W-1:0] s);
        if (s[PROD_W-1] || s == '0) begin
            return '0;
        end
        return clamp_mag(s);
    endfunction

    // one q4.12 channel, red in the high bits
    function automatic logic [GAIN_W-1:0] chan(input logic [RGB_W-1:0] p, input int c);
        return p[RGB_W-1-GAIN_W*c -: GAIN_W];
    endfunction

endpackage

// ===== rtl/core/pls_normalize.sv =====
module pls_normalize import pls_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  comp_t [VEC_N-1:0]       raw_i,
    output unit_t [VEC_N-1:0]       unit_o
);

    // magnitudes, largest one and its leading bit
    logic [CMP_W-1:0] mag_w [VEC_N];
    logic [CMP_W-1:0] top_w;
    logic [SH_W-1:0]  msb_w;

    always_comb begin
        top_w = '0;
        msb_w = '0;
        for (int i = 0; i < VEC_N; i++) begin
            mag_w[i] = raw_i[i][CMP_W-1] ? (~raw_i[i] + 1'b1) : raw_i[i];
            if (mag_w[i] > top_w) begin
                top_w = mag_w[i];
            end
        end
        for (int b = 0; b < CMP_W; b++) begin
            if (top_w[b]) begin
                msb_w = SH_W'(b);
            end
        end
    end

    logic [CMP_W-1:0] mag_a_reg [VEC_N];
    logic [VEC_N-1:0] neg_a_reg;
    logic [SH_W-1:0]  sh_a_reg;
    logic             zero_a_reg;
    logic [MAG_W-1:0] smag_b_reg [VEC_N];
    logic [VEC_N-1:0] neg_b_reg;
    logic             zero_b_reg;
    logic [SQ_W-1:0]  sq_c_reg [VEC_N];
    logic [MAG_W-1:0] smag_c_reg [VEC_N];
    logic [VEC_N-1:0] neg_c_reg;
    logic             zero_c_reg;

    // sqrt pipeline carries
    logic [SUM_W-1:0]             sx_reg     [0:SQRT_STEPS];
    logic [SUM_W-1:0]             sr_reg     [0:SQRT_STEPS];
    logic [VEC_N-1:0][MAG_W-1:0]  smag_s_reg [0:SQRT_STEPS];
    logic [VEC_N-1:0]             neg_s_reg  [0:SQRT_STEPS];
    logic                         zero_s_reg [0:SQRT_STEPS];

    // divider pipeline carries
    logic [VEC_N-1:0][REM_W-1:0]  drem_reg  [1:DIV_STEPS];
    logic [VEC_N-1:0][LEN_W-1:0]  dq_reg    [1:DIV_STEPS];
    logic [LEN_W-1:0]             dlen_reg  [1:DIV_STEPS];
    logic [VEC_N-1:0]             dneg_reg  [1:DIV_STEPS];
    logic                         dzero_reg [1:DIV_STEPS];

    unit_t [VEC_N-1:0] unit_reg;

    // scale, square and sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < VEC_N; i++) begin
                mag_a_reg[i]  <= mag_w[i];
                smag_b_reg[i] <= MAG_W'(mag_a_reg[i]) << sh_a_reg;
                sq_c_reg[i]   <= SQ_W'(smag_b_reg[i]) * SQ_W'(smag_b_reg[i]);
                smag_c_reg[i] <= smag_b_reg[i];
                smag_s_reg[0][i] <= smag_c_reg[i];
                neg_a_reg[i]  <= raw_i[i][CMP_W-1];
            end
            sh_a_reg   <= SH_W'(SCALE_MSB) - msb_w;
            zero_a_reg <= (top_w == '0);
            neg_b_reg  <= neg_a_reg;
            zero_b_reg <= zero_a_reg;
            neg_c_reg  <= neg_b_reg;
            zero_c_reg <= zero_b_reg;
            sx_reg[0]  <= SUM_W'(sq_c_reg[0]) + SUM_W'(sq_c_reg[1]) + SUM_W'(sq_c_reg[2]);
            sr_reg[0]  <= '0;
            neg_s_reg[0]  <= neg_c_reg;
            zero_s_reg[0] <= zero_c_reg;
        end
    end

    // floor square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [SUM_W-1:0] trial;
        assign trial = sr_reg[j] + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (sx_reg[j] >= trial) begin
                    sx_reg[j+1] <= sx_reg[j] - trial;
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + BIT;
                end else begin
                    sx_reg[j+1] <= sx_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
                smag_s_reg[j+1] <= smag_s_reg[j];
                neg_s_reg[j+1]  <= neg_s_reg[j];
                zero_s_reg[j+1] <= zero_s_reg[j];
            end
        end
    end

    // restoring divide of the scaled magnitudes by the length
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BPOS = DIV_STEPS - 1 - k;
        logic [VEC_N-1:0][REM_W-1:0] rem_in;
        logic [VEC_N-1:0][LEN_W-1:0] q_in;
        logic [LEN_W-1:0]            len_in;
        logic [VEC_N-1:0]            neg_in;
        logic                        zero_in;
        logic [REM_W-1:0]            den;

        if (k == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < VEC_N; i++) begin
                    rem_in[i] = REM_W'(smag_s_reg[SQRT_STEPS][i]) << Q_FRAC;
                    q_in[i]   = '0;
                end
            end
            assign len_in  = sr_reg[SQRT_STEPS][LEN_W-1:0];
            assign neg_in  = neg_s_reg[SQRT_STEPS];
            assign zero_in = zero_s_reg[SQRT_STEPS];
        end else begin : g_next
            assign rem_in  = drem_reg[k];
            assign q_in    = dq_reg[k];
            assign len_in  = dlen_reg[k];
            assign neg_in  = dneg_reg[k];
            assign zero_in = dzero_reg[k];
        end

        assign den = REM_W'(len_in) << BPOS;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < VEC_N; i++) begin
                    if (rem_in[i] >= den) begin
                        drem_reg[k+1][i] <= rem_in[i] - den;
                        dq_reg[k+1][i]   <= q_in[i] | (LEN_W'(1) << BPOS);
                    end else begin
                        drem_reg[k+1][i] <= rem_in[i];
                        dq_reg[k+1][i]   <= q_in[i];
                    end
                end
                dlen_reg[k+1]  <= len_in;
                dneg_reg[k+1]  <= neg_in;
                dzero_reg[k+1] <= zero_in;
            end
        end
    end

    // restore signs, zero vector stays zero
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < VEC_N; i++) begin
                if (dzero_reg[DIV_STEPS]) begin
                    unit_reg[i] <= '0;
                end else if (dneg_reg[DIV_STEPS][i]) begin
                    unit_reg[i] <= -UNIT_W'(dq_reg[DIV_STEPS][i]);
                end else begin
                    unit_reg[i] <= UNIT_W'(dq_reg[DIV_STEPS][i]);
                end
            end
        end
    end

    assign unit_o = unit_reg;

endmodule

// ===== rtl/core/phong_light_shader.sv =====
// Phong lighting term for one light at one surface point.
// Input stream: one beat per fragment carrying the view, normal and light
// direction vectors (signed q2.14), the light color (three q4.12) and the
// light strength (q16.16). Output stream: one beat per input beat with the
// saturated red, green and blue contributions (q16.16).
// Material gains and shininess are set through the write port; write them
// only while no beat is in flight.
// From input beat to output beat, the three vectors are first normalized
// (bit-serial square root over 32 stages and a restoring divide over 31
// stages), then the dot products and the reflection are formed, the
// specular angle is raised to the shininess (one exponent bit per stage)
// and the gains and the strength are applied.
// Throughput is one beat per clock. When an output beat waits with m_tready
// low the whole pipeline freezes and s_tready drops, so nothing is lost or
// repeated; with m_tvalid low the pipeline keeps moving.
// Reset clears all valid bits and sets the gains to zero and shininess to one.
module phong_light_shader import pls_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // view_x, view_y, view_z, normal_x, normal_y, normal_z,
    // light_x, light_y, light_z, light_color_rgb, light_strength
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // red_out, green_out, blue_out
    output logic [OUT_TW-1:0] m_tdata,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    logic adv;
    logic [TOTAL_LAT-1:0] vld_reg;

    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // material registers
    logic [RGB_W-1:0]   amb_gain_reg;
    logic [RGB_W-1:0]   dif_gain_reg;
    logic [RGB_W-1:0]   spc_gain_reg;
    logic [SHINE_W-1:0] shine_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_gain_reg <= '0;
            dif_gain_reg <= '0;
            spc_gain_reg <= '0;
            shine_reg    <= SHINE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_AMBIENT:   amb_gain_reg <= cfg_wr_data[RGB_W-1:0];
                REG_DIFFUSE:   dif_gain_reg <= cfg_wr_data[RGB_W-1:0];
                REG_SPECULAR:  spc_gain_reg <= cfg_wr_data[RGB_W-1:0];
                REG_SHININESS: shine_reg    <= cfg_wr_data[SHINE_W-1:0];
            endcase
        end
    end

    // valid bits and side data travel with the beat
    side_t side_reg [0:ST_F3-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0].color    <= s_tdata[VEC_N*VEC_N*CMP_W +: RGB_W];
            side_reg[0].strength <= s_tdata[VEC_N*VEC_N*CMP_W+RGB_W +: STR_W];
            for (int k = 1; k < ST_F3; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // vector normalization
    unit_t [VEC_N-1:0] nrm_v, nrm_n, nrm_l;

    pls_normalize u_norm_view (
        .aclk   (aclk),
        .en     (adv),
        .raw_i  (s_tdata[VEC_N*CMP_W-1:0]),
        .unit_o (nrm_v)
    );

    pls_normalize u_norm_normal (
        .aclk   (aclk),
        .en     (adv),
        .raw_i  (s_tdata[2*VEC_N*CMP_W-1:VEC_N*CMP_W]),
        .unit_o (nrm_n)
    );

    pls_normalize u_norm_light (
        .aclk   (aclk),
        .en     (adv),
        .raw_i  (s_tdata[3*VEC_N*CMP_W-1:2*VEC_N*CMP_W]),
        .unit_o (nrm_l)
    );

    // geometry stage registers
    logic signed [PROD_W-1:0] pnl_reg [VEC_N];
    logic signed [PROD_W-1:0] dnl_reg;
    logic signed [PROD_W-1:0] pqn4_reg [VEC_N];
    logic signed [PROD_W-1:0] prv6_reg [VEC_N];
    logic signed [PROD_W-1:0] drv7_reg;
    unit_t [VEC_N-1:0] n1_reg, l1_reg, v1_reg;
    unit_t [VEC_N-1:0] n2_reg, l2_reg, v2_reg;
    unit_t [VEC_N-1:0] n3_reg, l3_reg, v3_reg;
    unit_t [VEC_N-1:0] l4_reg, v4_reg;
    unit_t [VEC_N-1:0] r5_reg, v5_reg;
    unit_t             q3_reg;
    logic [Q_W-1:0]    diff3_reg, diff4_reg, diff5_reg, diff6_reg, diff7_reg;

    // reflection comb: q and r
    logic [PROD_W-1:0]        dnl_abs_w;
    logic [Q_W-1:0]           qmag_w;
    unit_t                    q_w;
    logic [PROD_W-1:0]        t2_abs_w [VEC_N];
    logic signed [PROD_W-1:0] w_w      [VEC_N];
    logic signed [PROD_W-1:0] x_w      [VEC_N];
    unit_t [VEC_N-1:0]        r_w;

    always_comb begin
        dnl_abs_w = dnl_reg[PROD_W-1] ? -dnl_reg : dnl_reg;
        qmag_w    = clamp_mag(dnl_abs_w);
        q_w       = dnl_reg[PROD_W-1] ? -UNIT_W'(qmag_w) : UNIT_W'(qmag_w);
        for (int i = 0; i < VEC_N; i++) begin
            t2_abs_w[i] = pqn4_reg[i][PROD_W-1] ? -(pqn4_reg[i] <<< 1) : (pqn4_reg[i] <<< 1);
            w_w[i] = pqn4_reg[i][PROD_W-1] ? -$signed(t2_abs_w[i] >> Q_FRAC)
                                           : $signed(t2_abs_w[i] >> Q_FRAC);
            x_w[i] = w_w[i] - PROD_W'($signed(l4_reg[i]));
            if (x_w[i] > ONE_Q30_S) begin
                r_w[i] = UNIT_W'(ONE_Q30_S);
            end else if (x_w[i] < -ONE_Q30_S) begin
                r_w[i] = UNIT_W'(-ONE_Q30_S);
            end else begin
                r_w[i] = UNIT_W'(x_w[i]);
            end
        end
    end

    // dot products, reflection, specular angle
    logic [Q_W-1:0] pw_acc_reg  [0:PW_STEPS];
    logic [Q_W-1:0] pw_base_reg [0:PW_STEPS];
    logic [Q_W-1:0] pw_diff_reg [0:PW_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < VEC_N; i++) begin
                pnl_reg[i]  <= PROD_W'($signed(nrm_n[i])) * PROD_W'($signed(nrm_l[i]));
                pqn4_reg[i] <= PROD_W'($signed(q3_reg)) * PROD_W'($signed(n3_reg[i]));
                prv6_reg[i] <= PROD_W'($signed(r5_reg[i])) * PROD_W'($signed(v5_reg[i]));
            end
            n1_reg <= nrm_n;
            l1_reg <= nrm_l;
            v1_reg <= nrm_v;
            dnl_reg <= pnl_reg[0] + pnl_reg[1] + pnl_reg[2];
            n2_reg <= n1_reg;
            l2_reg <= l1_reg;
            v2_reg <= v1_reg;
            diff3_reg <= clamp_pos(dnl_reg);
            q3_reg <= q_w;
            n3_reg <= n2_reg;
            l3_reg <= l2_reg;
            v3_reg <= v2_reg;
            l4_reg <= l3_reg;
            v4_reg <= v3_reg;
            diff4_reg <= diff3_reg;
            r5_reg <= r_w;
            v5_reg <= v4_reg;
            diff5_reg <= diff4_reg;
            diff6_reg <= diff5_reg;
            drv7_reg <= prv6_reg[0] + prv6_reg[1] + prv6_reg[2];
            diff7_reg <= diff6_reg;
            pw_base_reg[0] <= clamp_pos(drv7_reg);
            pw_acc_reg[0]  <= Q_W'(ONE_Q30);
            pw_diff_reg[0] <= diff7_reg;
        end
    end

    // power by squaring, one exponent bit per stage
    for (genvar p = 0; p < PW_STEPS; p++) begin : g_pow
        logic [2*Q_W-1:0] pa;
        logic [2*Q_W-1:0] pb;
        assign pa = (2*Q_W)'(pw_acc_reg[p]) * (2*Q_W)'(pw_base_reg[p]);
        assign pb = (2*Q_W)'(pw_base_reg[p]) * (2*Q_W)'(pw_base_reg[p]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                pw_acc_reg[p+1]  <= shine_reg[p] ? Q_W'(pa >> Q_FRAC) : pw_acc_reg[p];
                pw_base_reg[p+1] <= Q_W'(pb >> Q_FRAC);
                pw_diff_reg[p+1] <= pw_diff_reg[p];
            end
        end
    end

    // per channel gains and strength
    logic [AMB_W-1:0]  amb1_reg [3];
    logic [AMB_W-1:0]  amb2_reg [3];
    logic [AMB_W-1:0]  amb3_reg [3];
    logic [KDD_W-1:0]  kdd1_reg [3];
    logic [LCKS_W-1:0] lcks1_reg [3];
    logic [Q_W-1:0]    spec1_reg;
    logic [DIF_W-1:0]  dif2_reg [3];
    logic [DIF_W-1:0]  dif3_reg [3];
    logic [SP_W-1:0]   sp2_reg [3];
    logic [SPC_W-1:0]  spc3_reg [3];
    logic [TOT_W-1:0]  tot_w [3];
    logic [OUT_W-1:0]  out_reg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tot_w[c] = TOT_W'(amb3_reg[c]) + TOT_W'(dif3_reg[c]) + TOT_W'(spc3_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            spec1_reg <= pw_acc_reg[PW_STEPS];
            for (int c = 0; c < 3; c++) begin
                amb1_reg[c] <= AMB_W'(((GAIN_W+STR_W)'(chan(amb_gain_reg, c))
                               * (GAIN_W+STR_W)'(side_reg[ST_F1-1].strength)) >> AMB_SH);
                kdd1_reg[c] <= KDD_W'(chan(dif_gain_reg, c)) * KDD_W'(pw_diff_reg[PW_STEPS]);
                lcks1_reg[c] <= LCKS_W'(chan(side_reg[ST_F1-1].color, c))
                                * LCKS_W'(chan(spc_gain_reg, c));
                amb2_reg[c] <= amb1_reg[c];
                dif2_reg[c] <= DIF_W'(((KDD_W-DIF_SH1+STR_W)'(kdd1_reg[c] >> DIF_SH1)
                               * (KDD_W-DIF_SH1+STR_W)'(side_reg[ST_F1].strength)) >> DIF_SH2);
                sp2_reg[c] <= SP_W'(((LCKS_W+Q_W)'(lcks1_reg[c]) * (LCKS_W+Q_W)'(spec1_reg))
                              >> Q_FRAC);
                amb3_reg[c] <= amb2_reg[c];
                dif3_reg[c] <= dif2_reg[c];
                spc3_reg[c] <= SPC_W'(((SP_W+STR_W)'(sp2_reg[c])
                               * (SP_W+STR_W)'(side_reg[ST_F3-1].strength)) >> DIF_SH2);
                out_reg[c] <= (tot_w[c][TOT_W-1:OUT_W] != '0) ? '1 : tot_w[c][OUT_W-1:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            m_tdata[c*OUT_W +: OUT_W] = out_reg[c];
        end
    end

endmodule

// ===== tb/sv/phong_checker.sv =====
`timescale 1ns / 1ps

module phong_checker import pls_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_TW-1:0] m_tdata,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output int                fail_count,
    output int                pending
);

    typedef longint vec3_t [3];

    // shadow copy of the material registers
    logic [RGB_W-1:0]   ka_rgb;
    logic [RGB_W-1:0]   kd_rgb;
    logic [RGB_W-1:0]   ks_rgb;
    logic [SHINE_W-1:0] shine;

    // expected rgb beats, oldest first
    logic [OUT_TW-1:0] rgb_expected [$];

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale to a common exponent, then divide by the truncated length
    function automatic void normalize(input logic [3*CMP_W-1:0] raw, output vec3_t u);
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned top, sum, len, q;
        comp_t           c;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c = raw[CMP_W*i +: CMP_W];
            neg[i] = c[CMP_W-1];
            mag[i] = neg[i] ? longint'(-longint'(c)) : longint'(c);
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) begin
            u = '{0, 0, 0};
            return;
        end
        while (top < (64'd1 << 29)) begin
            top <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << 30) / len;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint pos_part(input longint s);
        longint t;
        if (s <= 0) return 0;
        t = s >>> 30;
        return (t > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : t;
    endfunction

    function automatic longint sym_clip(input longint x);
        longint one;
        one = 64'sd1 <<< 30;
        if (x > one) return one;
        if (x < -one) return -one;
        return x;
    endfunction

    function automatic logic [OUT_TW-1:0] shade(input logic [IN_TW-1:0] d);
        vec3_t             v, n, l, r;
        longint            dnl, drv, q, diff, ang;
        longint unsigned   spec, acc, base, inten, ka, kd, ks, lc, amb, dif, spc, total;
        logic [RGB_W-1:0]  color;
        logic [OUT_TW-1:0] res;
        logic [SHINE_W-1:0] e;
        normalize(d[0 +: 3*CMP_W], v);
        normalize(d[3*CMP_W +: 3*CMP_W], n);
        normalize(d[6*CMP_W +: 3*CMP_W], l);
        color = d[9*CMP_W +: RGB_W];
        inten = d[9*CMP_W+RGB_W +: STR_W];
        dnl = 0;
        drv = 0;
        for (int i = 0; i < 3; i++) dnl += n[i] * l[i];
        diff = pos_part(dnl);
        q = sym_clip(dnl / (64'sd1 <<< 30));
        for (int i = 0; i < 3; i++) r[i] = sym_clip((2 * q * n[i]) / (64'sd1 <<< 30) - l[i]);
        for (int i = 0; i < 3; i++) drv += r[i] * v[i];
        ang = pos_part(drv);
        // square and multiply from the low exponent bit
        acc = 64'd1 << 30;
        base = ang;
        e = shine;
        while (e != 0) begin
            if (e[0]) acc = (acc * base) >> 30;
            base = (base * base) >> 30;
            e >>= 1;
        end
        spec = acc;
        for (int c = 0; c < 3; c++) begin
            ka = ka_rgb[RGB_W-1-GAIN_W*c -: GAIN_W];
            kd = kd_rgb[RGB_W-1-GAIN_W*c -: GAIN_W];
            ks = ks_rgb[RGB_W-1-GAIN_W*c -: GAIN_W];
            lc = color[RGB_W-1-GAIN_W*c -: GAIN_W];
            amb = (ka * inten) >> 12;
            dif = (((kd * longint'(diff)) >> 18) * inten) >> 24;
            spc = ((((lc * ks) * spec) >> 30) * inten) >> 24;
            total = amb + dif + spc;
            res[OUT_W*c +: OUT_W] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        end
        return res;
    endfunction

    // register writes, input beats and output beats
    always @(posedge aclk) begin
        logic [OUT_TW-1:0] want;
        if (!aresetn) begin
            ka_rgb = '0;
            kd_rgb = '0;
            ks_rgb = '0;
            shine = 8'd1;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_AMBIENT:   ka_rgb = cfg_wr_data;
                    REG_DIFFUSE:   kd_rgb = cfg_wr_data;
                    REG_SPECULAR:  ks_rgb = cfg_wr_data;
                    REG_SHININESS: shine = cfg_wr_data[SHINE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) rgb_expected.push_back(shade(s_tdata));
            if (m_tvalid && m_tready) begin
                if (rgb_expected.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = rgb_expected.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (want[OUT_W*c +: OUT_W] !== m_tdata[OUT_W*c +: OUT_W]) begin
                            $display("%0t: channel %0d mismatch, expected %h, actual %h",
                                     $time, c, want[OUT_W*c +: OUT_W],
                                     m_tdata[OUT_W*c +: OUT_W]);
                            fail_count++;
                        end
                    end
                end
            end
        end
        pending = rgb_expected.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pls_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // view_x, view_y, view_z, normal_x, normal_y, normal_z,
    // light_x, light_y, light_z, light_color_rgb, light_strength
    logic [IN_TW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // red_out, green_out, blue_out
    logic [OUT_TW-1:0] m_tdata;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wr_data;
    int                fail_count;
    int                pending;
    bit                want_hold;

    phong_light_shader uut (.*);
    phong_checker      chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        m_tready = 1'b0;
        forever begin
            if (want_hold) begin
                want_hold = 0;
                m_tready <= 1'b0;
                for (int k = 0; k < 400; k++) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            for (int k = $urandom_range(5, 60); k > 0; k--) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic comp_t any_comp();
        case ($urandom_range(0, 19))
            0: return comp_t'(-32768);
            1: return comp_t'(32767);
            2: return '0;
            3: return comp_t'($urandom_range(0, 16) - 8);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic logic [IN_TW-1:0] frag(input comp_t c [9],
                                              input logic [RGB_W-1:0] color,
                                              input logic [STR_W-1:0] strength);
        logic [IN_TW-1:0] d;
        for (int i = 0; i < 9; i++) d[CMP_W*i +: CMP_W] = c[i];
        d[9*CMP_W +: RGB_W] = color;
        d[9*CMP_W+RGB_W +: STR_W] = strength;
        return d;
    endfunction

    // one beat, then a random gap at the end of a burst
    task automatic send_frag(input logic [IN_TW-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        if ($urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            for (int k = $urandom_range(1, 12); k > 0; k--) @(posedge aclk);
        end
    endtask

    task automatic load_material(input logic [RGB_W-1:0] ka, input logic [RGB_W-1:0] kd,
                                 input logic [RGB_W-1:0] ks, input logic [7:0] sh);
        logic [CFG_W-1:0] vals [4];
        vals = '{ka, kd, ks, CFG_W'(sh)};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= cfg_reg_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        for (int k = 0; k < 100; k++) @(posedge aclk);
    endtask

    // aligned vectors give strong diffuse and specular terms
    task automatic send_random();
        comp_t c [9];
        int    b [3];
        logic [STR_W-1:0] str;
        if ($urandom_range(0, 9) < 7) begin
            for (int j = 0; j < 3; j++) b[j] = $urandom_range(0, 32000) - 16000;
            for (int i = 0; i < 9; i++)
                c[i] = comp_t'(b[i % 3] + $urandom_range(0, 3000) - 1500);
            if ($urandom_range(0, 9) == 0) c[$urandom_range(0, 8)] = any_comp();
        end else begin
            for (int i = 0; i < 9; i++) c[i] = any_comp();
            if ($urandom_range(0, 9) == 0)
                for (int i = 3 * $urandom_range(0, 2), j = 0; j < 3; j++) c[i+j] = '0;
        end
        str = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
        send_frag(frag(c, RGB_W'({$urandom, $urandom}), str));
    endtask

    initial begin
        comp_t c [9];
        logic [RGB_W-1:0] g [3];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_AMBIENT;
        cfg_wr_data = '0;
        want_hold = 0;
        for (int k = 0; k < 10; k++) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: all gains zero
        c = '{default: comp_t'(16384)};
        send_frag(frag(c, '1, '1));
        drain();

        // full gains, highest exponent, saturation
        load_material('1, '1, '1, 8'd255);
        send_frag(frag(c, '1, '1));
        c = '{default: comp_t'(-32768)};
        send_frag(frag(c, '1, 32'h0001_0000));
        c = '{default: comp_t'(32767)};
        send_frag(frag(c, 48'h1000_1000_1000, 32'h0001_0000));
        c = '{default: '0};
        send_frag(frag(c, '1, '1));
        c = '{16384, 0, 0, 0, 0, 16384, 0, 0, 16384};
        send_frag(frag(c, '1, 32'h0002_0000));
        // light behind the surface
        c = '{0, 0, 16384, 0, 0, 16384, 0, 0, -16384};
        send_frag(frag(c, '1, 32'h0002_0000));
        // zero normal and zero light
        c = '{0, 0, 16384, 0, 0, 0, 0, 0, 16384};
        send_frag(frag(c, '1, 32'h0001_0000));
        c = '{0, 0, 16384, 0, 0, 16384, 0, 0, 0};
        send_frag(frag(c, '1, 32'h0001_0000));
        c = '{-32768, 32767, 1, 32767, -32768, -1, 1, -1, -32768};
        send_frag(frag(c, 48'hFFFF_0000_FFFF, 32'hFFFF_0000));
        drain();

        // exponent zero, including zero angle
        load_material(48'h1000_0800_0001, 48'h0001_1000_FFFF, 48'hFFFF_0001_1000, 8'd0);
        c = '{0, 0, -16384, 0, 0, 16384, 0, 16384, 0};
        send_frag(frag(c, '1, 32'h0001_0000));
        c = '{0, 0, 16384, 0, 0, 16384, 0, 0, 16384};
        send_frag(frag(c, '1, 32'h0001_0000));
        c = '{default: '0};
        send_frag(frag(c, '0, '0));
        c = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_frag(frag(c, '1, 32'h0000_0001));
        c = '{-1, -1, -1, 1, 1, 1, 1, 1, 1};
        send_frag(frag(c, '1, '1));
        drain();

        // random phases under several materials
        for (int ph = 0; ph < 6; ph++) begin
            for (int j = 0; j < 3; j++)
                g[j] = ($urandom_range(0, 1) != 0) ? RGB_W'({$urandom, $urandom})
                     : {16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                        16'($urandom_range(0, 8192))};
            load_material(g[0], g[1], g[2],
                          (ph == 5) ? 8'd0 : 8'($urandom_range(0, (ph < 2) ? 8 : 255)));
            if (ph == 2) want_hold = 1;
            for (int k = 0; k < 275; k++) send_random();
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pls_pkg.sv
rtl/core/pls_normalize.sv
rtl/core/phong_light_shader.sv
tb/sv/phong_checker.sv
tb/sv/tb_top.sv
